FILE: design/mbw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mbw_pkg;

  localparam int DIM_W    = 13;
  localparam int MAX_DIM  = 4096;
  localparam int COLOUR_W = 24;
  localparam int BYTE_W   = 8;
  localparam int HDR_LEN  = 62;
  localparam int PC_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int FSIZE_W  = 23;
  localparam int PAD_W    = 2;

  localparam logic [PC_W-1:0] PC_HDR = '0;
  localparam logic [PC_W-1:0] PC_PIX = PC_W'(HDR_LEN);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH, CFG_HEIGHT, CFG_WHITE, CFG_BLACK
  } cfg_reg_t;

  typedef enum logic [3:0] {
    SRC_LIT, SRC_FS0, SRC_FS1, SRC_FS2,
    SRC_W0, SRC_W1, SRC_H0, SRC_H1,
    SRC_WH0, SRC_WH1, SRC_WH2,
    SRC_BK0, SRC_BK1, SRC_BK2,
    SRC_PIX
  } src_t;

  typedef enum logic [1:0] {
    OP_NEXT, OP_END, OP_END_NOPAD, OP_PAD_LOOP
  } op_t;

  typedef struct packed {
    src_t             src;
    logic [BYTE_W-1:0] lit;
    op_t              op;
  } uword_t;

  typedef struct packed {
    logic              fire;
    src_t              src;
    logic [BYTE_W-1:0] lit;
    logic              last;
    logic              pix;
    logic              pad_dec;
  } dp_ctrl_t;

  typedef struct packed {
    logic slot_free;
    logic pix_emit;
    logic pad_zero;
    logic pad_one;
  } dp_stat_t;

  // Header bytes are steps 0..61, the pixel byte and its row padding follow.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{src: SRC_LIT, lit: 8'h00, op: OP_NEXT};
    case (pc)
      PC_W'(0):  w.lit = 8'h42;
      PC_W'(1):  w.lit = 8'h4D;
      PC_W'(2):  w.src = SRC_FS0;
      PC_W'(3):  w.src = SRC_FS1;
      PC_W'(4):  w.src = SRC_FS2;
      PC_W'(10): w.lit = BYTE_W'(HDR_LEN);
      PC_W'(14): w.lit = 8'd40;
      PC_W'(18): w.src = SRC_W0;
      PC_W'(19): w.src = SRC_W1;
      PC_W'(22): w.src = SRC_H0;
      PC_W'(23): w.src = SRC_H1;
      PC_W'(26): w.lit = 8'd1;
      PC_W'(28): w.lit = 8'd1;
      PC_W'(54): w.src = SRC_WH0;
      PC_W'(55): w.src = SRC_WH1;
      PC_W'(56): w.src = SRC_WH2;
      PC_W'(58): w.src = SRC_BK0;
      PC_W'(59): w.src = SRC_BK1;
      PC_W'(60): w.src = SRC_BK2;
      PC_W'(61): w.op  = OP_END;
      PC_W'(62): begin
        w.src = SRC_PIX;
        w.op  = OP_END_NOPAD;
      end
      PC_W'(63): w.op = OP_PAD_LOOP;
      default: ;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: design/mbw_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mbw_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic pixel_value;
  modport source (output valid, kind, pixel_value, input ready);
  modport sink (input valid, kind, pixel_value, output ready);
endinterface

interface mbw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_run;
  logic       end_of_file;
  modport source (output valid, data_byte, end_of_run, end_of_file, input ready);
  modport sink (input valid, data_byte, end_of_run, end_of_file, output ready);
endinterface
`default_nettype wire

FILE: design/mbw_seq.sv
`timescale 1ns / 1ps
`default_nettype none
module mbw_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              kind,
  input  mbw_pkg::dp_stat_t stat,
  output logic              busy,
  output mbw_pkg::dp_ctrl_t ctrl
);

  logic [mbw_pkg::PC_W-1:0] pc;
  logic [mbw_pkg::PC_W-1:0] pc_next;
  mbw_pkg::uword_t          word;
  logic                     fire;
  logic                     last;

  assign word = mbw_pkg::ucode(pc);
  assign fire = busy && stat.slot_free;

  always_comb begin
    last    = 1'b0;
    pc_next = pc;
    case (word.op)
      mbw_pkg::OP_NEXT: pc_next = pc + 1'b1;
      mbw_pkg::OP_END: last = 1'b1;
      mbw_pkg::OP_END_NOPAD: begin
        last    = stat.pad_zero;
        pc_next = pc + 1'b1;
      end
      mbw_pkg::OP_PAD_LOOP: last = stat.pad_one;
      default: ;
    endcase
  end

  always_comb begin
    ctrl.fire    = fire;
    ctrl.src     = word.src;
    ctrl.lit     = word.lit;
    ctrl.last    = last;
    ctrl.pix     = (word.op == mbw_pkg::OP_END_NOPAD) || (word.op == mbw_pkg::OP_PAD_LOOP);
    ctrl.pad_dec = fire && (word.op == mbw_pkg::OP_PAD_LOOP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= mbw_pkg::PC_HDR;
    end else if (accept) begin
      if (!kind) begin
        busy <= 1'b1;
        pc   <= mbw_pkg::PC_HDR;
      end else if (stat.pix_emit) begin
        busy <= 1'b1;
        pc   <= mbw_pkg::PC_PIX;
      end
    end else if (fire) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        pc <= pc_next;
      end
    end
  end

  a_hdr_entry: assert property (@(posedge clk) disable iff (rst)
    accept && !kind |=> busy && (pc == mbw_pkg::PC_HDR))
    else $error("header run did not start at step zero");

  a_pad_nonzero: assert property (@(posedge clk) disable iff (rst)
    busy && (word.op == mbw_pkg::OP_PAD_LOOP) |-> !stat.pad_zero)
    else $error("padding step entered with no padding left");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    fire && last |=> !busy)
    else $error("sequencer still busy after last beat");

endmodule
`default_nettype wire

FILE: design/mbw_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module mbw_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic                             kind,
  input  logic                             pixel_value,
  input  logic                             cfg_write,
  input  logic [mbw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbw_pkg::COLOUR_W-1:0]     cfg_data,
  input  mbw_pkg::dp_ctrl_t                ctrl,
  output mbw_pkg::dp_stat_t                stat,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [mbw_pkg::BYTE_W-1:0]       data_byte,
  output logic                             end_of_run,
  output logic                             end_of_file
);

  logic [mbw_pkg::DIM_W-1:0]    frame_width;
  logic [mbw_pkg::DIM_W-1:0]    frame_height;
  logic [mbw_pkg::COLOUR_W-1:0] white_colour;
  logic [mbw_pkg::COLOUR_W-1:0] black_colour;

  logic [mbw_pkg::DIM_W-1:0]  column_count;
  logic [mbw_pkg::DIM_W-1:0]  row_count;
  logic [mbw_pkg::BYTE_W-1:0] pack_byte;
  logic [2:0]                 bits_in_byte;
  logic                       frame_active;

  logic [mbw_pkg::BYTE_W-1:0] byte_hold;
  logic [mbw_pkg::PAD_W-1:0]  pad_cnt;
  logic                       eof_hold;
  logic [mbw_pkg::FSIZE_W-1:0] fsize;

  logic [mbw_pkg::DIM_W-1:0]  w;
  logic [mbw_pkg::DIM_W-1:0]  h;
  logic [mbw_pkg::DIM_W:0]    w_p31;
  logic [mbw_pkg::DIM_W:0]    w_p7;
  logic [7:0]                 blocks;
  logic [20:0]                row_words;
  logic [mbw_pkg::PAD_W-1:0]  pad_row;

  logic [3:0]                 bits;
  logic [mbw_pkg::BYTE_W-1:0] pack_new;
  logic [mbw_pkg::DIM_W-1:0]  col_new;
  logic [mbw_pkg::DIM_W-1:0]  row_new;
  logic                       row_end;
  logic                       frame_close;
  logic                       pix_emit;
  logic [2:0]                 shamt;
  logic [mbw_pkg::BYTE_W-1:0] pix_byte;
  logic [mbw_pkg::BYTE_W-1:0] mux_byte;
  logic                       slot_free;

  // Zero reads as one, oversize saturates.
  always_comb begin
    if (frame_width == '0) begin
      w = mbw_pkg::DIM_W'(1);
    end else if (frame_width > mbw_pkg::DIM_W'(mbw_pkg::MAX_DIM)) begin
      w = mbw_pkg::DIM_W'(mbw_pkg::MAX_DIM);
    end else begin
      w = frame_width;
    end
    if (frame_height == '0) begin
      h = mbw_pkg::DIM_W'(1);
    end else if (frame_height > mbw_pkg::DIM_W'(mbw_pkg::MAX_DIM)) begin
      h = mbw_pkg::DIM_W'(mbw_pkg::MAX_DIM);
    end else begin
      h = frame_height;
    end
  end

  assign w_p31     = {1'b0, w} + (mbw_pkg::DIM_W+1)'(31);
  assign w_p7      = {1'b0, w} + (mbw_pkg::DIM_W+1)'(7);
  assign blocks    = w_p31[12:5];
  assign row_words = blocks * h;
  // Padding brings the data bytes of a row up to a multiple of four.
  assign pad_row   = mbw_pkg::PAD_W'(2'd0 - w_p7[4:3]);

  assign bits        = {1'b0, bits_in_byte} + 4'd1;
  assign pack_new    = {pack_byte[6:0], pixel_value};
  assign col_new     = column_count + 1'b1;
  assign row_new     = row_count + 1'b1;
  assign row_end     = col_new >= w;
  assign frame_close = row_end && (row_new >= h);
  assign pix_emit    = frame_active && ((bits == 4'd8) || row_end);
  assign shamt       = 3'(4'd8 - bits);
  assign pix_byte    = pack_new << shamt;

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    stat.slot_free = slot_free;
    stat.pix_emit  = pix_emit;
    stat.pad_zero  = (pad_cnt == '0);
    stat.pad_one   = (pad_cnt == mbw_pkg::PAD_W'(1));
  end

  always_comb begin
    case (ctrl.src)
      mbw_pkg::SRC_LIT: mux_byte = ctrl.lit;
      mbw_pkg::SRC_FS0: mux_byte = fsize[7:0];
      mbw_pkg::SRC_FS1: mux_byte = fsize[15:8];
      mbw_pkg::SRC_FS2: mux_byte = {1'b0, fsize[22:16]};
      mbw_pkg::SRC_W0:  mux_byte = w[7:0];
      mbw_pkg::SRC_W1:  mux_byte = {3'b000, w[12:8]};
      mbw_pkg::SRC_H0:  mux_byte = h[7:0];
      mbw_pkg::SRC_H1:  mux_byte = {3'b000, h[12:8]};
      mbw_pkg::SRC_WH0: mux_byte = white_colour[7:0];
      mbw_pkg::SRC_WH1: mux_byte = white_colour[15:8];
      mbw_pkg::SRC_WH2: mux_byte = white_colour[23:16];
      mbw_pkg::SRC_BK0: mux_byte = black_colour[7:0];
      mbw_pkg::SRC_BK1: mux_byte = black_colour[15:8];
      mbw_pkg::SRC_BK2: mux_byte = black_colour[23:16];
      mbw_pkg::SRC_PIX: mux_byte = byte_hold;
      default:          mux_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= mbw_pkg::DIM_W'(1);
      frame_height <= mbw_pkg::DIM_W'(1);
      white_colour <= '1;
      black_colour <= '0;
    end else if (cfg_write) begin
      case (mbw_pkg::cfg_reg_t'(cfg_index))
        mbw_pkg::CFG_WIDTH:  frame_width  <= cfg_data[mbw_pkg::DIM_W-1:0];
        mbw_pkg::CFG_HEIGHT: frame_height <= cfg_data[mbw_pkg::DIM_W-1:0];
        mbw_pkg::CFG_WHITE:  white_colour <= cfg_data;
        mbw_pkg::CFG_BLACK:  black_colour <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    fsize <= {row_words, 2'b00} + mbw_pkg::FSIZE_W'(mbw_pkg::HDR_LEN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      pack_byte    <= '0;
      bits_in_byte <= '0;
      frame_active <= 1'b0;
      pad_cnt      <= '0;
      eof_hold     <= 1'b0;
    end else if (accept && !kind) begin
      column_count <= '0;
      row_count    <= '0;
      pack_byte    <= '0;
      bits_in_byte <= '0;
      frame_active <= 1'b1;
    end else if (accept && frame_active) begin
      if (row_end) begin
        column_count <= '0;
        pack_byte    <= '0;
        bits_in_byte <= '0;
        row_count    <= frame_close ? '0 : row_new;
        frame_active <= !frame_close;
      end else begin
        column_count <= col_new;
        pack_byte    <= (bits == 4'd8) ? '0 : pack_new;
        bits_in_byte <= bits[2:0];
      end
      pad_cnt  <= row_end ? pad_row : '0;
      eof_hold <= frame_close;
    end else if (ctrl.pad_dec) begin
      pad_cnt <= pad_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_hold <= pix_byte;
    end
  end

  // Output beat register: load on a step, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      data_byte   <= mux_byte;
      end_of_run  <= ctrl.last;
      end_of_file <= ctrl.last && ctrl.pix && eof_hold;
    end
  end

  a_eof_closed: assert property (@(posedge clk) disable iff (rst)
    ctrl.fire && ctrl.last && ctrl.pix && eof_hold |-> !frame_active)
    else $error("end of file beat while frame still open");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !frame_active |-> (column_count == '0) && (bits_in_byte == '0))
    else $error("packing state left over outside a frame");

endmodule
`default_nettype wire

FILE: design/mono_bmp_stream_writer.sv
// Header item: 62 beats after the accept cycle, ready low until the last is staged.
// Pixel item: no beat when it completes no byte; else the packed byte, then row padding (0..3) bytes.
// The microcode step counter stages one beat per step, one per cycle while the output is free.
// Synchronous active-high reset: no frame open, width and height 1,
// palette white/black, output empty. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module mono_bmp_stream_writer (
  input  logic                          clk,
  input  logic                          rst,
  mbw_in_if.sink                        pixels,
  mbw_out_if.source                     stream,
  input  logic                          cfg_write,
  input  logic [mbw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbw_pkg::COLOUR_W-1:0]  cfg_data
);

  logic              busy;
  logic              accept;
  mbw_pkg::dp_ctrl_t ctrl;
  mbw_pkg::dp_stat_t stat;

  assign pixels.ready = !busy;
  assign accept       = pixels.valid && !busy;

  mbw_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .kind   (pixels.kind),
    .stat   (stat),
    .busy   (busy),
    .ctrl   (ctrl)
  );

  mbw_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .kind        (pixels.kind),
    .pixel_value (pixels.pixel_value),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .ctrl        (ctrl),
    .stat        (stat),
    .out_ready   (stream.ready),
    .out_valid   (stream.valid),
    .data_byte   (stream.data_byte),
    .end_of_run  (stream.end_of_run),
    .end_of_file (stream.end_of_file)
  );

endmodule
`default_nettype wire
